// ----- hw/rtl/kppq_pkg.sv -----
`timescale 1ns / 1ps

package kppq_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned IN_PAY_W  = 32;
  localparam int unsigned OUT_PAY_W = 32;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } seq_state_e;

  typedef struct packed {
    mode_e                 mode;
    logic [KEY_W-1:0]      dest_key;
    logic [IN_PAY_W-1:0]   payload_in;
  } kppq_in_t;

  typedef struct packed {
    status_e               status;
    logic [OUT_PAY_W-1:0]  payload_out;
    logic [OCC_W-1:0]      occupancy;
  } kppq_out_t;

endpackage

// ----- hw/rtl/kppq_ram.sv -----
`timescale 1ns / 1ps

module kppq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kppq_seq.sv -----
`timescale 1ns / 1ps

module kppq_seq #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  kppq_pkg::kppq_in_t  item_i,
  input  logic                res_take_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output kppq_pkg::kppq_out_t res_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = kppq_pkg::KEY_W + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  kppq_pkg::seq_state_e state_q, state_d;
  kppq_pkg::mode_e      mode_q, mode_d;
  kppq_pkg::status_e    status_q, status_d;
  logic [kppq_pkg::KEY_W-1:0] key_q, key_d;
  logic [PAYLOAD_BITS-1:0]    pay_q, pay_d;
  logic [PAYLOAD_BITS-1:0]    rpay_q, rpay_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           count_q, count_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  logic [kppq_pkg::KEY_W-1:0] rd_key;
  logic [PAYLOAD_BITS-1:0]    rd_pay;
  logic [IDX_W-1:0]           idx_next;
  logic [CNT_W-1:0]           idx_inc;
  logic                       hit;

  logic [kppq_pkg::IN_PAY_W+PAYLOAD_BITS-1:0]  pay_in_wide;
  logic [kppq_pkg::OUT_PAY_W+PAYLOAD_BITS-1:0] pay_out_wide;
  logic [kppq_pkg::OCC_W+CNT_W-1:0]            occ_wide;

  kppq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_key   = mem_rdata[ENT_W-1 -: kppq_pkg::KEY_W];
  assign rd_pay   = mem_rdata[PAYLOAD_BITS-1:0];
  assign idx_next = idx_q + IDX_W'(1);
  assign idx_inc  = CNT_W'(idx_q) + CNT_W'(1);
  assign hit      = (rd_key == key_q);

  assign pay_in_wide  = {{PAYLOAD_BITS{1'b0}}, item_i.payload_in};
  assign pay_out_wide = {{kppq_pkg::OUT_PAY_W{1'b0}}, rpay_q};
  assign occ_wide     = {{kppq_pkg::OCC_W{1'b0}}, count_q};

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    pay_d       = pay_q;
    status_d    = status_q;
    rpay_d      = rpay_q;
    idx_d       = idx_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = {key_q, pay_q};
    mem_raddr   = idx_next;
    res_valid_o = 1'b0;

    unique case (state_q)
      kppq_pkg::S_IDLE: begin
        if (start_i) begin
          mode_d  = item_i.mode;
          key_d   = item_i.dest_key;
          pay_d   = pay_in_wide[PAYLOAD_BITS-1:0];
          state_d = kppq_pkg::S_DISPATCH;
        end
      end
      kppq_pkg::S_DISPATCH: begin
        rpay_d    = '0;
        status_d  = kppq_pkg::ST_OK;
        state_d   = kppq_pkg::S_FINISH;
        idx_d     = '0;
        mem_raddr = '0;
        case (mode_q) inside
          kppq_pkg::MODE_ENQ: begin
            if (count_q == DEPTH_CNT) begin
              status_d = kppq_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IDX_W-1:0];
              count_d   = count_q + CNT_W'(1);
            end
          end
          kppq_pkg::MODE_DEQ, kppq_pkg::MODE_PEEK: begin
            if (count_q == '0) begin
              status_d = kppq_pkg::ST_MISS;
            end else begin
              state_d = kppq_pkg::S_SEARCH;
            end
          end
          kppq_pkg::MODE_CLEAR: begin
            count_d = '0;
          end
          default: begin
            count_d = count_q;
          end
        endcase
      end
      kppq_pkg::S_SEARCH: begin
        if (hit) begin
          rpay_d = rd_pay;
          if (mode_q == kppq_pkg::MODE_DEQ) begin
            state_d = kppq_pkg::S_SHIFT;
          end else begin
            state_d = kppq_pkg::S_FINISH;
          end
        end else if (idx_inc >= count_q) begin
          status_d = kppq_pkg::ST_MISS;
          state_d  = kppq_pkg::S_FINISH;
        end else begin
          idx_d = idx_next;
        end
      end
      kppq_pkg::S_SHIFT: begin
        if (idx_inc < count_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = mem_rdata;
          mem_raddr = idx_q + IDX_W'(2);
          idx_d     = idx_next;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = kppq_pkg::S_FINISH;
        end
      end
      kppq_pkg::S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = kppq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kppq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kppq_pkg::S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    status_q <= status_d;
    rpay_q   <= rpay_d;
  end

  assign busy_o            = (state_q != kppq_pkg::S_IDLE);
  assign res_o.status      = status_q;
  assign res_o.payload_out = pay_out_wide[kppq_pkg::OUT_PAY_W-1:0];
  assign res_o.occupancy   = occ_wide[kppq_pkg::OCC_W-1:0];

endmodule

// ----- hw/rtl/keyed_pending_packet_queue.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i, in_stall_o   in_data_i  (mode, dest_key, payload_in)
// out       output     out_valid_o, out_stall_i out_data_o (status, payload_out, occupancy)
//
// One transaction at a time: enqueue and clear go from dispatch straight to finish,
// while a peek or a dequeue also searches the keys, and a dequeue that hits compacts.
// Their duration is set by the linear key search and the compaction, both through the
// single read and write port of the entry memory.
// Reset empties the queue at once; no clearing pass is needed.
// The result sits in an output register, so a stalled output holds the next
// transaction back only when its own result is ready.

module keyed_pending_packet_queue #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kppq_pkg::kppq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kppq_pkg::kppq_out_t out_data_o
);

  localparam logic [kppq_pkg::OCC_W-1:0] FULL_OCC = QUEUE_DEPTH[kppq_pkg::OCC_W-1:0];

  logic                busy;
  logic                start;
  logic                res_valid;
  logic                res_take;
  kppq_pkg::kppq_out_t res;

  logic                out_valid_q, out_valid_d;
  kppq_pkg::kppq_out_t out_data_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  kppq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (in_data_i),
    .res_take_i  (res_take),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("Queue did not go busy after accepting a transaction.");

  a_no_payload_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != kppq_pkg::ST_OK |-> out_data_o.payload_out == '0)
    else $error("Failed transaction returned a nonzero payload.");

  a_full_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == kppq_pkg::ST_FULL |-> out_data_o.occupancy == FULL_OCC)
    else $error("Full status reported while the queue was not full.");

  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (QUEUE_DEPTH > 31) || (32'(out_data_o.occupancy) <= QUEUE_DEPTH))
    else $error("Occupancy exceeds the queue depth.");

  a_result_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> busy && !start)
    else $error("Result loaded while the sequencer was idle.");

endmodule
